// ===== rtl/rsc_pkg.sv =====
// Package for the RGBI-plus-sync pixel capture block.
// Holds video timing constants, register indexes and the result record type.
// No dependencies; imported by rsc_core, rsc_outq and the top level.
package rsc_pkg;

    // Video timing
    localparam int LINE_WIDTH  = 640;
    localparam int LINE_COUNT  = 240;
    localparam int HSYNC_PULSE = 24;
    localparam int VSYNC_PULSE = 128;
    localparam int HS_BIT      = 4;
    localparam int VS_BIT      = 5;

    // Field widths
    localparam int SAMPLE_W = 7;
    localparam int WORD_W   = 16;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int FRAME_W  = 32;

    // Derived limits
    localparam logic [WORD_W-1:0]  ROW_BYTES   = WORD_W'(LINE_WIDTH / 4);
    localparam logic [WORD_W-1:0]  X_LIMIT     = WORD_W'(LINE_WIDTH / 2);
    localparam logic [WORD_W-1:0]  Y_LIMIT     = WORD_W'(LINE_COUNT);
    localparam logic [WORD_W-1:0]  HS_MID      = WORD_W'(HSYNC_PULSE / 2);
    localparam logic [WORD_W-1:0]  VS_RUN      = WORD_W'(VSYNC_PULSE);
    localparam logic [WORD_W-1:0]  POS_MAX     = 16'h7fff;
    localparam logic [WORD_W-1:0]  RUN_MAX     = 16'hffff;
    localparam logic [FRAME_W-1:0] SWAP_FRAMES = 32'd10;
    localparam int                 LED_BIT     = 5;
    localparam logic [3:0]         COLOR_MASK  = 4'hf;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATE_VSYNC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SKIP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y        = 2'd2;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic              swap_buffer;
        logic              led;
    } t_result;

endpackage

// ===== rtl/rsc_core.sv =====
// Capture core: input register, configuration registers, position/line/sync
// tracking state and the single-pass decode of one sample into a result.
// Depends on rsc_pkg.
module rsc_core import rsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [SAMPLE_W-1:0]  i_sample,
    output logic                 o_in_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_room,
    output logic                 o_res_valid,
    output t_result              o_res
);

    // Configuration
    logic              r_separate_vsync;
    logic [CFG_W-1:0]  r_left_skip;
    logic [CFG_W-1:0]  r_shift_y;

    // Input register
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;

    // Tracking state
    logic signed [WORD_W-1:0] r_pos_x,  n_pos_x;
    logic signed [WORD_W-1:0] r_line_y, n_line_y;
    logic [WORD_W-1:0]        r_sync_run, n_sync_run;
    logic [SAMPLE_W-1:0]      r_prev_sample, n_prev_sample;
    logic [FRAME_W-1:0]       r_frames_seen, n_frames_seen;

    logic                     w_step;
    logic                     w_accept;
    logic signed [WORD_W-1:0] w_pos_inc;
    logic signed [WORD_W-1:0] w_line_after_hs;
    logic signed [WORD_W-1:0] w_start_x;
    logic signed [WORD_W-1:0] w_frame_y;
    logic [WORD_W-1:0]        w_run_inc;
    logic                     w_in_sync;
    logic                     w_hsync_hit;
    logic                     w_vsync;
    logic                     w_frame;
    logic                     w_pixel;
    logic [WORD_W-1:0]        w_row_base;
    logic [ADDR_W-1:0]        w_address;

    // Process the held sample when the output side has room
    assign w_step     = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Decode the held sample against the current state
    always_comb begin
        w_pos_inc = (r_pos_x == $signed(POS_MAX)) ? r_pos_x : r_pos_x + 16'sd1;
        w_run_inc = (r_sync_run == RUN_MAX) ? r_sync_run : r_sync_run + 16'd1;

        if (r_separate_vsync) begin
            w_in_sync = !r_sample[HS_BIT] || !r_sample[VS_BIT];
            w_vsync   = !r_sample[VS_BIT];
        end else begin
            w_in_sync = !r_sample[HS_BIT];
            w_vsync   = (w_run_inc >= VS_RUN);
        end

        w_hsync_hit = w_in_sync && !r_sample[HS_BIT] && (r_sync_run == HS_MID);

        // Line start: negated skip, forced odd
        w_start_x = (-$signed({8'd0, r_left_skip}) - 16'sd1) | 16'sd1;
        w_line_after_hs = (w_hsync_hit && r_line_y != $signed(POS_MAX)) ?
                          r_line_y + 16'sd1 : r_line_y;
        w_frame_y = -$signed({8'd0, r_shift_y}) - 16'sd1;

        w_frame = w_in_sync && w_vsync && !w_line_after_hs[WORD_W-1];

        w_pixel = !w_in_sync && w_pos_inc[0] && !w_pos_inc[WORD_W-1] &&
                  !r_line_y[WORD_W-1] &&
                  ($unsigned(w_pos_inc) < X_LIMIT) &&
                  ($unsigned(r_line_y) < Y_LIMIT);

        w_row_base = $unsigned(r_line_y) * ROW_BYTES;
        w_address  = w_row_base + {1'b0, w_pos_inc[WORD_W-1:1]};

        // Next state
        n_pos_x       = w_hsync_hit ? w_start_x : w_pos_inc;
        n_line_y      = w_frame ? w_frame_y : w_line_after_hs;
        n_frames_seen = w_frame ? r_frames_seen + 32'd1 : r_frames_seen;
        n_sync_run    = r_sync_run;
        n_prev_sample = r_prev_sample;
        if (w_in_sync) begin
            n_sync_run = w_run_inc;
        end else if (!w_pos_inc[0]) begin
            n_sync_run    = '0;
            n_prev_sample = r_sample;
        end

        // Result record
        o_res_valid = w_step && (w_frame || w_pixel);
        o_res.kind  = w_frame ? KIND_FRAME : KIND_PIXEL;
        o_res.led   = n_frames_seen[LED_BIT];
        if (w_frame) begin
            o_res.address     = '0;
            o_res.data        = '0;
            o_res.swap_buffer = (r_frames_seen > SWAP_FRAMES);
        end else begin
            o_res.address     = w_address;
            o_res.data        = {r_sample[3:0] & COLOR_MASK, r_prev_sample[3:0] & COLOR_MASK};
            o_res.swap_buffer = 1'b0;
        end
    end

    // Hold configuration, input register and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separate_vsync <= 1'b0;
            r_left_skip      <= '0;
            r_shift_y        <= '0;
            r_in_valid       <= 1'b0;
            r_pos_x          <= '0;
            r_line_y         <= '0;
            r_sync_run       <= '0;
            r_prev_sample    <= '0;
            r_frames_seen    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEPARATE_VSYNC: r_separate_vsync <= i_cfg_data[0];
                    CFG_LEFT_SKIP:      r_left_skip      <= i_cfg_data;
                    CFG_SHIFT_Y:        r_shift_y        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_pos_x       <= n_pos_x;
                r_line_y      <= n_line_y;
                r_sync_run    <= n_sync_run;
                r_prev_sample <= n_prev_sample;
                r_frames_seen <= n_frames_seen;
            end
        end
    end

    // Capture the sample payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
        end
    end

    // A frame start always leaves the line counter negative
    a_frame_line_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_frame) |=> r_line_y[WORD_W-1])
        else $error("line counter not negative after frame start");

    // A pixel write leaves pos_x on an odd sample
    a_pixel_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_pixel) |=> r_pos_x[0])
        else $error("pixel write at even position");

    // A held sample that cannot advance stays put
    a_hold_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !i_room) |=> (r_in_valid && $stable(r_sample)))
        else $error("held sample lost while output full");

endmodule

// ===== rtl/rsc_outq.sv =====
// Two-entry result queue between the capture core and the output channel.
// Lets the core advance while one finished result waits on the consumer.
// Depends on rsc_pkg.
module rsc_outq import rsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_stall
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop   = o_valid && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_res   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue occupancy out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'd2))
        else $error("push into full result queue");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("pop did not reduce occupancy");

endmodule

// ===== rtl/rgbi_sync_pixel_capture_top.sv =====
// Top level of the RGBI-plus-sync pixel capture block.
// Instantiates rsc_core and rsc_outq; depends on rsc_pkg.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_sample
//   out     | output    | o_out_valid / i_out_stall | o_kind o_address o_data
//           |           |                           | o_swap_buffer o_led
//   cfg     | input     | i_cfg_we                  | i_cfg_index i_cfg_data
//
// One sample per clock is sustained unless the output queue is full: a sample is registered,
// decoded when the queue has room and its result (if any) written into a two-entry output queue.
// A result is offered on o_out_valid from the queue, which is registered after the input register.
// i_rst_n is synchronous; it clears the configuration and all tracking state.
// The input stalls only when a sample is held and the output queue is full.
module rgbi_sync_pixel_capture_top import rsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [SAMPLE_W-1:0]  i_sample,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic [ADDR_W-1:0]    o_address,
    output logic [DATA_W-1:0]    o_data,
    output logic                 o_swap_buffer,
    output logic                 o_led,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic    w_room;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    // Decode samples
    rsc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_sample    (i_sample),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_room      (w_room),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Buffer results toward the consumer
    rsc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .o_res   (w_out),
        .i_stall (i_out_stall)
    );

    assign o_kind        = w_out.kind;
    assign o_address     = w_out.address;
    assign o_data        = w_out.data;
    assign o_swap_buffer = w_out.swap_buffer;
    assign o_led         = w_out.led;

endmodule

// ===== tb/rsc_capture_checker.sv =====
// Checker for the RGBI-plus-sync pixel capture block: watches both channels and the register port.
// It predicts pixel writes and frame starts and compares each output transaction field by field.
// Depends on rsc_pkg.
module rsc_capture_checker import rsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_kind,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [DATA_W-1:0]    i_data,
    input  logic                 i_swap_buffer,
    input  logic                 i_led,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_pixel_count,
    output int                   o_frame_starts
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies
    logic               sep_vsync;
    logic [7:0]         lead_skip;
    logic [7:0]         line_shift;

    // Tracking state of the capture
    logic signed [15:0] col_pos;
    logic signed [15:0] row_pos;
    logic [15:0]        sync_len;
    logic [6:0]         held_sample;
    logic [31:0]        frame_total;

    // Pixel writes and frame starts still owed by the block, oldest first
    t_result            capture_q[$];

    function automatic logic signed [15:0] sat_step(input logic signed [15:0] v);
        return (v == 16'sh7fff) ? v : v + 16'sd1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Advance the capture by one sample and queue the result it causes, if any
    task automatic predict_capture(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] watch;
        logic                vs_hit;
        logic signed [15:0]  line_start;
        int                  col_i;
        int                  row_i;
        t_result             r;
        watch = SAMPLE_W'(1 << HS_BIT) | (sep_vsync ? SAMPLE_W'(1 << VS_BIT) : '0);
        r = '0;
        col_pos = sat_step(col_pos);
        if ((s & watch) != watch) begin
            // Take the line start in the middle of a low HS run
            if (!s[HS_BIT] && sync_len == HS_MID) begin
                line_start = -$signed({8'd0, lead_skip}) - 16'sd1;
                if (lead_skip[0]) begin
                    line_start = line_start + 16'sd1;
                end
                row_pos = sat_step(row_pos);
                col_pos = line_start;
            end
            if (sync_len != RUN_MAX) begin
                sync_len = sync_len + 16'd1;
            end
            vs_hit = sep_vsync ? !s[VS_BIT] : (sync_len >= VS_RUN);
            // Ignore a repeated vertical sync while the line count is negative
            if (vs_hit && row_pos >= 0) begin
                r.kind        = KIND_FRAME;
                r.swap_buffer = (frame_total > SWAP_FRAMES);
                frame_total   = frame_total + 32'd1;
                row_pos       = -$signed({8'd0, line_shift}) - 16'sd1;
                r.led         = frame_total[LED_BIT];
                capture_q.push_back(r);
            end
        end else if (col_pos[0]) begin
            col_i = col_pos;
            row_i = row_pos;
            if (col_i >= 0 && row_i >= 0 && col_i < LINE_WIDTH / 2 && row_i < LINE_COUNT) begin
                r.kind    = KIND_PIXEL;
                r.address = ADDR_W'(row_i * (LINE_WIDTH / 4) + col_i / 2);
                r.data    = {s[3:0], held_sample[3:0]};
                r.led     = frame_total[LED_BIT];
                capture_q.push_back(r);
            end
        end else begin
            sync_len    = '0;
            held_sample = s;
        end
    endtask

    // Compare one output transaction with the oldest prediction
    task automatic check_result();
        t_result want;
        if (capture_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d address 0x%0h data 0x%0h",
                                      i_kind, i_address, i_data));
        end else begin
            want = capture_q.pop_front();
            check_field("kind", i_kind, want.kind);
            check_field("address", i_address, want.address);
            check_field("data", i_data, want.data);
            check_field("swap_buffer", i_swap_buffer, want.swap_buffer);
            check_field("led", i_led, want.led);
            if (want.kind == KIND_FRAME) begin
                o_frame_starts++;
            end else begin
                o_pixel_count++;
            end
        end
    endtask

    // Watch the channels at every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sep_vsync   = 1'b0;
            lead_skip   = '0;
            line_shift  = '0;
            col_pos     = '0;
            row_pos     = '0;
            sync_len    = '0;
            held_sample = '0;
            frame_total = '0;
            capture_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEPARATE_VSYNC: sep_vsync  = i_cfg_data[0];
                    CFG_LEFT_SKIP:      lead_skip  = i_cfg_data[7:0];
                    CFG_SHIFT_Y:        line_shift = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_capture(i_sample);
            end
        end
        o_pending = capture_q.size();
    end

endmodule

// ===== tb/rgbi_sync_pixel_capture_top_test.sv =====
// Testbench top for rgbi_sync_pixel_capture_top: clock, reset, sample and register stimulus.
// Checking is done by rsc_capture_checker beside the block; depends on rsc_pkg.
module rgbi_sync_pixel_capture_top_test;
    import rsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD   = 300;
    localparam int HS_RUN      = HSYNC_PULSE / 2 + 1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic [SAMPLE_W-1:0]  i_sample = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_kind;
    logic [ADDR_W-1:0]    o_address;
    logic [DATA_W-1:0]    o_data;
    logic                 o_swap_buffer;
    logic                 o_led;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int   fail_count;
    int   pending_results;
    int   pixel_count;
    int   frame_starts;
    int   sample_count;
    int   setting_count;
    int   cycle_count;
    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;
    bit   long_hold = 1'b0;
    logic sep_mode = 1'b0;
    int   skip_now;
    event long_hold_go;

    rgbi_sync_pixel_capture_top dut (.*);

    rsc_capture_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_kind         (o_kind),
        .i_address      (o_address),
        .i_data         (o_data),
        .i_swap_buffer  (o_swap_buffer),
        .i_led          (o_led),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results),
        .o_pixel_count  (pixel_count),
        .o_frame_starts (frame_starts)
    );

    always #5 i_clk = ~i_clk;

    // Stall the output a random number of cycles after each transaction, or for a long hold
    initial begin
        int   rx_wait;
        logic stall_now;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                rx_wait = rx_idle_on ? $urandom_range(0, 6) : 0;
            end
            @(negedge i_clk);
            stall_now = long_hold || rx_wait > 0;
            if (rx_wait > 0) begin
                rx_wait--;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall_now = 1'b1;
            end
            i_out_stall <= stall_now;
        end
    end

    // Hold the output off for a long stretch on request
    initial begin
        forever begin
            @(long_hold_go);
            @(posedge i_clk);
            long_hold = 1'b1;
            repeat (LONG_HOLD) @(posedge i_clk);
            long_hold = 1'b0;
        end
    end

    // End the run at the cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] pin_word(input logic hs_n, input logic vs_n,
                                                     input logic [3:0] rgbi, input logic spare);
        logic [SAMPLE_W-1:0] w;
        w              = '0;
        w[3:0]         = rgbi;
        w[SAMPLE_W-1]  = spare;
        w[HS_BIT]      = hs_n;
        w[VS_BIT]      = vs_n;
        return w;
    endfunction

    // Offer one sample and wait until the transaction is taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sample_count++;
    endtask

    // HS low run; VS stays high where it is watched
    task automatic send_sync(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            send_sample(pin_word(1'b0, sep_mode ? 1'b1 : 1'($urandom), 4'($urandom),
                                 1'($urandom)));
        end
    endtask

    // Visible samples with random colors
    task automatic send_active(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            send_sample(pin_word(1'b1, sep_mode ? 1'b1 : 1'($urandom), 4'($urandom),
                                 1'($urandom)));
        end
    endtask

    task automatic send_line(input int sync_n, input int active_n);
        send_sync(sync_n);
        send_active(active_n);
    endtask

    // VS pin low in separate mode, a long composite run otherwise
    task automatic send_vsync();
        int n;
        int k;
        if (sep_mode) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
                send_sample(pin_word(1'($urandom), 1'b0, 4'($urandom), 1'($urandom)));
            end
        end else begin
            send_sync($urandom_range(VSYNC_PULSE, VSYNC_PULSE + 12));
        end
    endtask

    task automatic send_noise(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            send_sample(SAMPLE_W'($urandom));
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all three registers while the block is idle
    task automatic set_mode(input logic sep, input logic [7:0] skip, input logic [7:0] shift);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SEPARATE_VSYNC;
        i_cfg_data  <= CFG_W'(sep);
        @(negedge i_clk);
        i_cfg_index <= CFG_LEFT_SKIP;
        i_cfg_data  <= CFG_W'(skip);
        @(negedge i_clk);
        i_cfg_index <= CFG_SHIFT_Y;
        i_cfg_data  <= CFG_W'(shift);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sep_mode = sep;
        skip_now = skip;
        setting_count++;
    endtask

    // Mostly well-formed lines and frames, with broken syncs and noise mixed in
    task automatic run_random(input int n_items);
        int stop_at;
        int pick;
        stop_at = sample_count + n_items;
        while (sample_count < stop_at) begin
            if ($urandom_range(0, 15) == 0) tx_idle_on = !tx_idle_on;
            if ($urandom_range(0, 15) == 0) rx_idle_on = !rx_idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_line($urandom_range(HS_RUN, HS_RUN + 5),
                          ($urandom_range(0, 11) == 0) ? skip_now + $urandom_range(300, 340)
                                                       : $urandom_range(1, 40));
            end else if (pick < 75) begin
                if (sep_mode || $urandom_range(0, 3) == 0) send_vsync();
            end else if (pick < 87) begin
                send_sync($urandom_range(1, HS_RUN - 1));
                send_active($urandom_range(1, 6));
            end else begin
                send_noise($urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        int k;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: sample extremes, frame start, pixel pairs, repeated and broken syncs
        set_mode(1'b0, 8'd0, 8'd0);
        send_sample(7'h7f);
        send_sample(7'h00);
        send_sync(VSYNC_PULSE);
        send_sync(HS_RUN);
        send_sample(pin_word(1'b1, 1'b1, 4'h0, 1'b0));
        send_sample(pin_word(1'b1, 1'b1, 4'hf, 1'b1));
        send_sample(pin_word(1'b1, 1'b1, 4'hf, 1'b1));
        send_sample(pin_word(1'b1, 1'b1, 4'h0, 1'b0));
        send_sync(20);
        send_sync(5);
        send_active(3);
        send_line(HS_RUN, 2);
        // Hold the output off while a line wider than the window keeps arriving
        -> long_hold_go;
        send_line(HS_RUN, 330);

        // Burst of frames to walk the swap flag and the activity bit
        set_mode(1'b1, 8'd0, 8'd0);
        for (k = 0; k < 32; k++) begin
            send_line(HS_RUN, 2);
            send_vsync();
        end

        // Largest skips: a line start far left, a frame start far above the window
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_mode(1'b1, 8'd255, 8'd255);
        send_line(HS_RUN, 2);
        send_vsync();
        for (k = 0; k < 2; k++) send_line(HS_RUN, 2);

        // Random phases over several register settings
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_mode(1'b0, 8'd0, 8'd0);
        run_random(50);
        set_mode(1'b1, 8'd0, 8'd0);
        run_random(50);
        set_mode(1'b0, 8'd1, 8'd2);
        run_random(50);
        set_mode(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 3)));
        run_random(50);
        set_mode(1'b0, 8'($urandom_range(0, 20)), 8'd0);
        run_random(50);

        drain();
        repeat (6) @(posedge i_clk);
        $display("Run fed %0d samples through %0d register settings;",
                 sample_count, setting_count);
        $display("checked %0d pixel writes and %0d frame starts.", pixel_count, frame_starts);
        if (fail_count == 0 && pending_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
